>>> design/gamepad_output_report_framer_top_defines.svh
// Assertion macros shared by the checkers of the report framer.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef GAMEPAD_OUTPUT_REPORT_FRAMER_TOP_DEFINES_SVH
`define GAMEPAD_OUTPUT_REPORT_FRAMER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GORF_ASSERT_SAME(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GORF_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

>>> design/gorf_pkg.sv
`timescale 1ns / 1ps

package gorf_pkg;

  localparam int WordCount = 20;
  localparam int IdxW      = $clog2(WordCount);
  localparam logic [IdxW-1:0] CrcWordIdx  = IdxW'(WordCount - 2);
  localparam logic [IdxW-1:0] LastWordIdx = IdxW'(WordCount - 1);

  localparam int AddrW = 6;
  localparam int DataW = 64;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcOnes = 32'hFFFF_FFFF;

  localparam logic [7:0] ReportId    = 8'hA2;
  localparam logic [7:0] ReportTag   = 8'h31;
  localparam logic [7:0] HdrFlags    = 8'h10;
  localparam logic [7:0] ValidFlag0  = 8'h0F;
  localparam logic [7:0] ValidFlag1  = 8'h15;
  localparam logic [7:0] MicMuteBits = 8'h02;
  localparam logic [7:0] ReleaseBit  = 8'h08;
  localparam logic [7:0] MuteCtrl    = 8'h10;
  localparam logic [7:0] LedFlags    = 8'h03;
  localparam logic [7:0] LedSetup    = 8'h02;
  localparam logic [7:0] BrightMax   = 8'h02;
  localparam logic [7:0] PlayerMask  = 8'h1F;

  localparam logic [2:0] FullBytes = 3'd4;
  localparam logic [2:0] LastBytes = 3'd3;

  typedef enum logic [2:0] {
    REG_RUMBLE  = 3'd0,
    REG_RGB     = 3'd1,
    REG_IND     = 3'd2,
    REG_RT_LOW  = 3'd3,
    REG_RT_HIGH = 3'd4,
    REG_LT_LOW  = 3'd5,
    REG_LT_HIGH = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] rumble_levels;
    logic [23:0] lightbar_rgb;
    logic [24:0] indicator_settings;
    logic [63:0] rt_low;
    logic [23:0] rt_high;
    logic [63:0] lt_low;
    logic [23:0] lt_high;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic            load;
    logic [IdxW-1:0] word_idx;
  } dp_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] acc_in, input logic [7:0] data);
    logic [31:0] acc;
    acc = acc_in ^ {24'h0, data};
    for (int b = 0; b < 8; b++) begin
      acc = acc[0] ? ((acc >> 1) ^ CrcPoly) : (acc >> 1);
    end
    return acc;
  endfunction

  // Little-endian: bits 7:0 enter the CRC first.
  function automatic logic [31:0] crc_word(input logic [31:0] acc_in, input logic [31:0] data);
    logic [31:0] acc;
    acc = acc_in;
    for (int n = 0; n < 4; n++) begin
      acc = crc_byte(acc, data[8*n +: 8]);
    end
    return acc;
  endfunction

endpackage

>>> design/gorf_regs.sv
`timescale 1ns / 1ps

module gorf_regs
  import gorf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [AddrW-1:0] cfg_paddr,
  input  logic [DataW-1:0] cfg_pwdata,
  output logic [DataW-1:0] cfg_prdata,
  output logic             cfg_pready,
  output cfg_t             cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t reg_idx;
  logic     wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[AddrW-1:3]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_RUMBLE:  cfg_nxt.rumble_levels      = cfg_pwdata[15:0];
        REG_RGB:     cfg_nxt.lightbar_rgb       = cfg_pwdata[23:0];
        REG_IND:     cfg_nxt.indicator_settings = cfg_pwdata[24:0];
        REG_RT_LOW:  cfg_nxt.rt_low             = cfg_pwdata[63:0];
        REG_RT_HIGH: cfg_nxt.rt_high            = cfg_pwdata[23:0];
        REG_LT_LOW:  cfg_nxt.lt_low             = cfg_pwdata[63:0];
        REG_LT_HIGH: cfg_nxt.lt_high            = cfg_pwdata[23:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RUMBLE:  cfg_prdata = {48'h0, cfg_r.rumble_levels};
      REG_RGB:     cfg_prdata = {40'h0, cfg_r.lightbar_rgb};
      REG_IND:     cfg_prdata = {39'h0, cfg_r.indicator_settings};
      REG_RT_LOW:  cfg_prdata = cfg_r.rt_low;
      REG_RT_HIGH: cfg_prdata = {40'h0, cfg_r.rt_high};
      REG_LT_LOW:  cfg_prdata = cfg_r.lt_low;
      REG_LT_HIGH: cfg_prdata = {40'h0, cfg_r.lt_high};
      default:     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> design/gorf_ctrl.sv
`timescale 1ns / 1ps

module gorf_ctrl
  import gorf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  state_t          state_r, state_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            start;
  logic            load;

  assign in_stall  = (state_r != ST_IDLE);
  assign start     = in_valid & (state_r == ST_IDLE);
  // A word moves into the output register whenever that register is free or drains now.
  assign load      = (state_r == ST_RUN) & (~out_valid_r | ~out_stall);
  assign out_valid = out_valid_r;

  assign cmd.start    = start;
  assign cmd.load     = load;
  assign cmd.word_idx = idx_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          idx_nxt   = '0;
        end
      end
      ST_RUN: begin
        if (load) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == LastWordIdx) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> design/gorf_dp.sv
`timescale 1ns / 1ps

module gorf_dp
  import gorf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  cfg_t        cfg,
  input  logic        in_led_release,
  output logic [31:0] out_frame_word,
  output logic [2:0]  out_valid_bytes,
  output logic        out_last_word
);

  logic [3:0]  seq_r, seq_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        release_r;
  logic [31:0] word_r;
  logic [2:0]  nbytes_r;
  logic        last_r;

  logic [31:0] word;
  logic [31:0] crc_fin;
  logic        mic_mute;
  logic [7:0]  flags1;
  logic [7:0]  mute_byte;
  logic [7:0]  bright;
  logic [7:0]  bright_sat;
  logic [7:0]  players;

  assign mic_mute   = cfg.indicator_settings[24];
  assign flags1     = ValidFlag1 | (mic_mute ? MicMuteBits : 8'h00)
                    | (release_r ? ReleaseBit : 8'h00);
  assign mute_byte  = mic_mute ? MuteCtrl : 8'h00;
  assign bright     = cfg.indicator_settings[15:8];
  assign bright_sat = (bright > BrightMax) ? BrightMax : bright;
  assign players    = cfg.indicator_settings[23:16] & PlayerMask;

  // Bytes 72 to 74 are always zero, so the final CRC folds in three zero bytes.
  assign crc_fin = crc_byte(crc_byte(crc_byte(crc_r, 8'h00), 8'h00), 8'h00) ^ CrcOnes;

  always_comb begin
    case (cmd.word_idx)
      5'd0:        word = {HdrFlags, seq_r, 4'h0, ReportTag, ReportId};
      5'd1:        word = {cfg.rumble_levels, flags1, ValidFlag0};
      5'd3:        word = {cfg.rt_low[15:0], mute_byte, cfg.indicator_settings[7:0]};
      5'd4:        word = cfg.rt_low[47:16];
      5'd5:        word = {cfg.rt_high[15:0], cfg.rt_low[63:48]};
      5'd6:        word = {cfg.lt_low[23:0], cfg.rt_high[23:16]};
      5'd7:        word = cfg.lt_low[55:24];
      5'd8:        word = {cfg.lt_high, cfg.lt_low[63:56]};
      5'd10:       word = {8'h00, LedFlags, 16'h0000};
      5'd11:       word = {players, bright_sat, LedSetup, 8'h00};
      5'd12:       word = {8'h00, cfg.lightbar_rgb};
      CrcWordIdx:  word = {crc_fin[7:0], 24'h000000};
      LastWordIdx: word = {8'h00, crc_r[31:8]};
      default:     word = 32'h0;
    endcase
  end

  always_comb begin
    seq_nxt = seq_r;
    crc_nxt = crc_r;
    if (cmd.start) begin
      crc_nxt = CrcOnes;
    end else if (cmd.load) begin
      if (cmd.word_idx == CrcWordIdx) begin
        crc_nxt = crc_fin;
      end else if (cmd.word_idx < CrcWordIdx) begin
        crc_nxt = crc_word(crc_r, word);
      end
      if (cmd.word_idx == '0) begin
        seq_nxt = seq_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
    end else begin
      seq_r <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    if (cmd.start) begin
      release_r <= in_led_release;
    end
    if (cmd.load) begin
      word_r   <= word;
      nbytes_r <= (cmd.word_idx == LastWordIdx) ? LastBytes : FullBytes;
      last_r   <= (cmd.word_idx == LastWordIdx);
    end
  end

  assign out_frame_word  = word_r;
  assign out_valid_bytes = nbytes_r;
  assign out_last_word   = last_r;

endmodule

>>> design/gamepad_output_report_framer_top.sv
`timescale 1ns / 1ps

// Each accepted request produces one 79-byte output report as 20 little-endian
// 32-bit words, the last marked by out_last_word with three valid bytes and a
// zero pad byte; the report ends with a reflected CRC-32 over bytes 0 to 74.
// The word sequencer moves one word per cycle into the output register while
// the CRC folds in four bytes per cycle, as long as the output does not stall,
// and a new request is taken the cycle after the last word is loaded. Registers
// sit at byte address 8*i on the 64-bit configuration port. The user must see
// that they are written only while no report is in flight; the block does not
// enforce this.
module gamepad_output_report_framer_top
  import gorf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [AddrW-1:0] cfg_paddr,
  input  logic [DataW-1:0] cfg_pwdata,
  output logic [DataW-1:0] cfg_prdata,
  output logic             cfg_pready,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_led_release,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      out_frame_word,
  output logic [2:0]       out_valid_bytes,
  output logic             out_last_word
);

  cfg_t    cfg;
  dp_cmd_t cmd;

  gorf_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  gorf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  gorf_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg             (cfg),
    .in_led_release  (in_led_release),
    .out_frame_word  (out_frame_word),
    .out_valid_bytes (out_valid_bytes),
    .out_last_word   (out_last_word)
  );

endmodule

>>> design/gorf_checker.sv
`timescale 1ns / 1ps

`include "gamepad_output_report_framer_top_defines.svh"

module gorf_checker
  import gorf_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [31:0]      out_frame_word,
  input logic [2:0]       out_valid_bytes,
  input logic             out_last_word
);

  // A stalled word must stay put until it is taken.
  `GORF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_frame_word), "stalled output word changed")

  // Only the final word of a report is short.
  `GORF_ASSERT_SAME(a_byte_count, out_valid, (out_last_word && out_valid_bytes == LastBytes) || (!out_last_word && out_valid_bytes == FullBytes), "valid_bytes does not match last_word")

  // Once a request is taken, no other is taken while its report is built.
  `GORF_ASSERT_NEXT(a_busy_after_start, in_valid && !in_stall, in_stall, "request taken while a report was in flight")

  // Two reports cannot end in consecutive transfers.
  `GORF_ASSERT_NEXT(a_no_double_last, out_valid && !out_stall && out_last_word, !(out_valid && out_last_word), "last word repeated")

endmodule

bind gamepad_output_report_framer_top gorf_checker u_gorf_checker (.*);
